// File: src/utf8v_pkg.sv
// utf8v_pkg: shared types, byte-class constants and decode functions
// for the utf-8 stream validator
// no dependencies
package utf8v_pkg;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] TWO_OVLONG = 8'h1E;
	localparam logic [7:0] SURR_LEAD  = 8'hED;
	localparam logic [7:0] SURR_MASK  = 8'hA0;
	localparam logic [7:0] L3_LOW     = 8'h0F;
	localparam logic [7:0] S3_BITS    = 8'h20;
	localparam logic [7:0] L4_LOW     = 8'h07;
	localparam logic [7:0] S4_BITS    = 8'h30;
	localparam logic [7:0] L5_LOW     = 8'h03;
	localparam logic [7:0] S5_BITS    = 8'h38;
	localparam logic [7:0] L6_LOW     = 8'h01;
	localparam logic [7:0] S6_BITS    = 8'h3E;

	localparam int TRAIL_W = 3;

	typedef struct packed {
		logic [TRAIL_W-1:0] trail_left;
		logic [7:0]         lead_value;
		logic               expect_second;
		logic               failed;
	} utf8v_state_t;

	typedef struct packed {
		logic               bad;
		logic [TRAIL_W-1:0] trails;
	} lead_info_t;

	// number of continuation bytes a lead byte announces
	function automatic lead_info_t lead_trails(input logic [7:0] b);
		lead_info_t r;
		r = '{bad: 1'b0, trails: '0};
		if (b[7] == 1'b0)              r.trails = 3'd0;
		else if (b[7:5] == 3'b110)     r.trails = 3'd1;
		else if (b[7:4] == 4'b1110)    r.trails = 3'd2;
		else if (b[7:3] == 5'b11110)   r.trails = 3'd3;
		else if (b[7:2] == 6'b111110)  r.trails = 3'd4;
		else if (b[7:1] == 7'b1111110) r.trails = 3'd5;
		else                           r.bad = 1'b1;
		return r;
	endfunction

	// overlong and surrogate checks on lead and second byte
	function automatic logic second_reject(input logic [7:0] lead, input logic [7:0] second);
		logic r;
		if (lead[7:4] == 4'b1110) begin
			r = ((lead == SURR_LEAD) && ((second & SURR_MASK) == SURR_MASK))
				|| (((lead & L3_LOW) == 8'h00) && ((second & S3_BITS) == 8'h00));
		end else if (lead[7:3] == 5'b11110) begin
			r = ((lead & L4_LOW) == 8'h00) && ((second & S4_BITS) == 8'h00);
		end else if (lead[7:2] == 6'b111110) begin
			r = ((lead & L5_LOW) == 8'h00) && ((second & S5_BITS) == 8'h00);
		end else begin
			r = ((lead & L6_LOW) == 8'h00) && ((second & S6_BITS) == 8'h00);
		end
		return r;
	endfunction

endpackage

// File: src/utf8_stream_validator_top.sv
// utf8_stream_validator_top: utf-8 (one to six byte legacy form) stream checker
// depends on utf8v_pkg and utf8v_step
//
// usage
//   input channel  : in_valid / in_ready, payload data_byte and final_byte.
//                    one byte per transfer, final_byte high on the last byte
//                    of a text; texts are never empty.
//   output channel : out_valid / out_ready, payload text_valid. exactly one
//                    transfer per text, raised by its final byte; bytes that
//                    are not final produce nothing.
//   verdict path   : the final byte is held in the input register, then its
//                    verdict is loaded into the verdict register, which drives
//                    out_valid; a stall on the output can come between.
//   throughput     : one byte per cycle unless a final byte waits on a full
//                    verdict register; decode and compare logic feeds the
//                    decoder state from the input register, so the next byte follows at once.
//   stall          : while a verdict waits unclaimed, non-final bytes keep
//                    flowing; only a second final byte waits in the input
//                    register, which then drops in_ready.
//   reset          : arst_n clears the input and output valid flags and the
//                    decoder state, so the first byte is read as a lead byte.
module utf8_stream_validator_top
	import utf8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       text_valid
);

	// input register
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         final_s1;

	// decoder state held across bytes of a text
	utf8v_state_t state_q;
	utf8v_state_t state_nxt;
	logic         verdict;

	// result register
	logic         out_valid_q;
	logic         text_valid_q;

	logic         out_free;
	logic         fire_s1;

	// a final byte needs room in the result register; others never wait
	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!final_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

	utf8v_step u_step (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.final_byte (final_s1),
		.nxt        (state_nxt),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register: loads on a final byte, empties on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && final_s1) begin
			text_valid_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign text_valid = text_valid_q;

endmodule

// File: src/utf8v_step.sv
// utf8v_step: next-state and verdict logic for one byte
// depends on utf8v_pkg
module utf8v_step
	import utf8v_pkg::*;
(
	input  utf8v_state_t cur,
	input  logic [7:0]   data_byte,
	input  logic         final_byte,
	output utf8v_state_t nxt,
	output logic         verdict
);

	lead_info_t   li;
	utf8v_state_t upd;

	always_comb begin
		li  = lead_trails(data_byte);
		upd = cur;
		if (!cur.failed) begin
			if (cur.trail_left == '0) begin
				if (li.bad) begin
					upd.failed = 1'b1;
				end else if (li.trails == 3'd1) begin
					// two-byte form must carry more than seven bits
					if ((data_byte & TWO_OVLONG) == 8'h00) upd.failed = 1'b1;
					else upd.trail_left = 3'd1;
				end else if (li.trails != 3'd0) begin
					upd.trail_left    = li.trails;
					upd.lead_value    = data_byte;
					upd.expect_second = 1'b1;
				end
			end else begin
				if ((data_byte & CONT_MASK) != CONT_CODE) begin
					upd.failed = 1'b1;
				end else begin
					if (cur.expect_second) begin
						if (second_reject(cur.lead_value, data_byte)) upd.failed = 1'b1;
						upd.expect_second = 1'b0;
					end
					upd.trail_left = cur.trail_left - 3'd1;
				end
			end
		end
		verdict = !upd.failed && (upd.trail_left == '0);
		nxt     = final_byte ? utf8v_state_t'('0) : upd;
	end

endmodule

// File: src/utf8v_checker.sv
// utf8v_checker: port-level checks for the utf-8 stream validator
// binds to utf8_stream_validator_top; no package use
module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       final_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       text_valid
);

	// a stalled verdict holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_valid))
		else $error("verdict changed while stalled");

	// a final byte transfer has its verdict showing once it has passed the input and result registers
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && final_byte |-> ##2 out_valid)
		else $error("no verdict after a final byte");

	// with the result register empty the input is never held off
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// reset clears the output
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind utf8_stream_validator_top utf8v_checker u_utf8v_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.final_byte (final_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.text_valid (text_valid)
);
